FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HSP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HSP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/hsp_pkg.sv
// ----------------------------------------------------------------------------
// hsp_pkg
// Types, constants and character helpers for the HTTP status line parser.
// ----------------------------------------------------------------------------
package hsp_pkg;

    localparam int LINE_BYTE_W     = 8;
    localparam int LINE_LIMIT_W    = 11;
    localparam int VERSION_MINOR_W = 4;
    localparam int STATUS_W        = 10;
    localparam int REASON_W        = 10;
    localparam int LINE_LENGTH_W   = 11;

    localparam int MAX_LINE_DEFAULT = 1024;
    localparam int LINE_LIMIT_RESET = 1024;
    localparam int LINE_LIMIT_MIN   = 16;
    localparam int CODE_LIMIT       = 600;
    localparam int CODE_MIN         = 100;

    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_Z = 8'h7A;
    localparam logic [7:0] CASE_GAP = 8'h20;

    typedef enum logic [1:0] {
        OUT_MORE = 2'd0,
        OUT_DONE = 2'd1,
        OUT_FAIL = 2'd2
    } t_outcome;

    typedef struct packed {
        t_outcome                   outcome;
        logic                       version_major;
        logic [VERSION_MINOR_W-1:0] version_minor;
        logic [STATUS_W-1:0]        status_value;
        logic [REASON_W-1:0]        reason_offset;
        logic [REASON_W-1:0]        reason_length;
        logic [LINE_LENGTH_W-1:0]   line_length;
    } t_result;

    function automatic logic is_blank(input logic [7:0] c);
        return c inside {CH_SPACE, CH_TAB};
    endfunction

    function automatic logic is_decimal(input logic [7:0] c);
        return c inside {[CH_ZERO:CH_NINE]};
    endfunction

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        return (c inside {[CH_LOW_A:CH_LOW_Z]}) ? c - CASE_GAP : c;
    endfunction

endpackage

FILE: rtl/hsp_byte_if.sv
// ----------------------------------------------------------------------------
// hsp_byte_if
// Valid/ready channel carrying one status line byte per word.
// ----------------------------------------------------------------------------
interface hsp_byte_if;
    import hsp_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [LINE_BYTE_W-1:0] line_byte;

    modport source (output valid, output line_byte, input ready);
    modport sink   (input valid, input line_byte, output ready);
endinterface

FILE: rtl/hsp_result_if.sv
// ----------------------------------------------------------------------------
// hsp_result_if
// Valid/ready channel carrying one parse result per word.
// ----------------------------------------------------------------------------
interface hsp_result_if;
    import hsp_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [1:0]                 outcome;
    logic                       version_major;
    logic [VERSION_MINOR_W-1:0] version_minor;
    logic [STATUS_W-1:0]        status_value;
    logic [REASON_W-1:0]        reason_offset;
    logic [REASON_W-1:0]        reason_length;
    logic [LINE_LENGTH_W-1:0]   line_length;

    modport source (
        output valid, output outcome, output version_major, output version_minor,
        output status_value, output reason_offset, output reason_length,
        output line_length, input ready
    );
    modport sink (
        input valid, input outcome, input version_major, input version_minor,
        input status_value, input reason_offset, input reason_length,
        input line_length, output ready
    );
endinterface

FILE: rtl/hsp_cfg_if.sv
// ----------------------------------------------------------------------------
// hsp_cfg_if
// Write channel for the line limit register.
// ----------------------------------------------------------------------------
interface hsp_cfg_if;
    import hsp_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [LINE_LIMIT_W-1:0] line_limit;

    modport source (output valid, output line_limit, input ready);
    modport sink   (input valid, input line_limit, output ready);
endinterface

FILE: rtl/hsp_in_stage.sv
// ----------------------------------------------------------------------------
// hsp_in_stage
// Input register: holds one byte until the parser core consumes it.
// ----------------------------------------------------------------------------
module hsp_in_stage (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    hsp_byte_if.sink                      i_line,
    input  logic                          i_step,
    output logic                          o_valid,
    output logic [hsp_pkg::LINE_BYTE_W-1:0] o_byte
);
    import hsp_pkg::*;

    logic                   r_valid;
    logic [LINE_BYTE_W-1:0] r_byte;

    // Take a new word when none is held or the held one leaves in this cycle.
    assign i_line.ready = !r_valid || i_step;
    assign o_valid      = r_valid;
    assign o_byte       = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_line.valid && i_line.ready) begin
            r_valid <= 1'b1;
        end else if (i_step) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_line.valid && i_line.ready) begin
            r_byte <= i_line.line_byte;
        end
    end
endmodule

FILE: rtl/hsp_core.sv
// ----------------------------------------------------------------------------
// hsp_core
// Status line state machine: one byte per step, produces one result per byte.
// ----------------------------------------------------------------------------
module hsp_core #(
    parameter int MAX_LINE = hsp_pkg::MAX_LINE_DEFAULT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    hsp_cfg_if.sink                         i_cfg,
    input  logic                            i_step,
    input  logic [hsp_pkg::LINE_BYTE_W-1:0] i_byte,
    output hsp_pkg::t_result                o_res
);
    import hsp_pkg::*;

    localparam int POS_W       = $clog2(MAX_LINE + 1);
    localparam int CMP_W       = (POS_W > LINE_LIMIT_W) ? POS_W : LINE_LIMIT_W;
    localparam int LIMIT_RESET = (MAX_LINE < LINE_LIMIT_RESET) ? MAX_LINE : LINE_LIMIT_RESET;
    localparam int CODE_ACC_W  = STATUS_W + 3;

    typedef enum logic [3:0] {
        PH_SKIP      = 4'd0,
        PH_H         = 4'd1,
        PH_HT        = 4'd2,
        PH_HTT       = 4'd3,
        PH_HTTP      = 4'd4,
        PH_SLASH     = 4'd5,
        PH_MAJOR     = 4'd6,
        PH_DOT       = 4'd7,
        PH_MINOR     = 4'd8,
        PH_PRE_CODE  = 4'd9,
        PH_CODE      = 4'd10,
        PH_POST_CODE = 4'd11,
        PH_REASON    = 4'd12,
        PH_CR        = 4'd13
    } t_phase;

    t_phase                     r_phase, n_phase;
    logic [POS_W-1:0]           r_pos, n_pos;
    logic                       r_major, n_major;
    logic [VERSION_MINOR_W-1:0] r_minor, n_minor;
    logic [STATUS_W-1:0]        r_code, n_code;
    logic [POS_W-1:0]           r_rstart, n_rstart;
    logic [POS_W-1:0]           r_rlen, n_rlen;
    logic [POS_W-1:0]           r_limit;

    t_outcome                   res;
    logic [CODE_ACC_W-1:0]      code_acc;
    logic [3:0]                 digit;
    logic [POS_W-1:0]           pos_inc;
    logic [POS_W-1:0]           rlen_done;
    logic [CMP_W-1:0]           cfg_ext;
    logic [CMP_W-1:0]           cfg_clamped;
    logic [POS_W+REASON_W-1:0]  rstart_ext;
    logic [POS_W+REASON_W-1:0]  rlen_ext;
    logic [POS_W+LINE_LENGTH_W-1:0] len_ext;

    assign i_cfg.ready = 1'b1;

    // Clamp the requested limit into the supported range at write time.
    assign cfg_ext     = CMP_W'(i_cfg.line_limit);
    assign cfg_clamped = (cfg_ext < CMP_W'(LINE_LIMIT_MIN)) ? CMP_W'(LINE_LIMIT_MIN) :
                         (cfg_ext > CMP_W'(MAX_LINE))       ? CMP_W'(MAX_LINE)       :
                                                              cfg_ext;

    assign digit    = i_byte[3:0];
    assign code_acc = {r_code, 3'b000} + {2'b00, r_code, 1'b0} + CODE_ACC_W'(digit);
    assign pos_inc  = r_pos + POS_W'(1);

    always_comb begin
        n_phase  = r_phase;
        n_pos    = r_pos;
        n_major  = r_major;
        n_minor  = r_minor;
        n_code   = r_code;
        n_rstart = r_rstart;
        n_rlen   = r_rlen;
        res      = OUT_MORE;

        case (r_phase)
            PH_SKIP: begin
                if (to_upper(i_byte) == CH_H) begin
                    n_phase = PH_H;
                end else if (!is_blank(i_byte)) begin
                    res = OUT_FAIL;
                end
            end
            PH_H: begin
                if (to_upper(i_byte) == CH_T) n_phase = PH_HT;
                else res = OUT_FAIL;
            end
            PH_HT: begin
                if (to_upper(i_byte) == CH_T) n_phase = PH_HTT;
                else res = OUT_FAIL;
            end
            PH_HTT: begin
                if (to_upper(i_byte) == CH_P) n_phase = PH_HTTP;
                else res = OUT_FAIL;
            end
            PH_HTTP: begin
                if (i_byte == CH_SLASH) n_phase = PH_SLASH;
                else res = OUT_FAIL;
            end
            PH_SLASH: begin
                if (i_byte inside {CH_ZERO, CH_ONE}) begin
                    n_major = i_byte[0];
                    n_phase = PH_MAJOR;
                end else begin
                    res = OUT_FAIL;
                end
            end
            PH_MAJOR: begin
                if (i_byte == CH_DOT) n_phase = PH_DOT;
                else res = OUT_FAIL;
            end
            PH_DOT: begin
                // Version 1.x allows minor 0 or 1 only.
                if (is_decimal(i_byte) && !(r_major && digit > 4'd1)) begin
                    n_minor = digit;
                    n_phase = PH_MINOR;
                end else begin
                    res = OUT_FAIL;
                end
            end
            PH_MINOR: begin
                if (is_blank(i_byte)) n_phase = PH_PRE_CODE;
                else res = OUT_FAIL;
            end
            PH_PRE_CODE: begin
                if (is_decimal(i_byte)) begin
                    n_code  = STATUS_W'(digit);
                    n_phase = PH_CODE;
                end else if (!is_blank(i_byte)) begin
                    res = OUT_FAIL;
                end
            end
            PH_CODE: begin
                if (is_decimal(i_byte)) begin
                    if (code_acc >= CODE_ACC_W'(CODE_LIMIT)) res = OUT_FAIL;
                    else n_code = code_acc[STATUS_W-1:0];
                end else if (is_blank(i_byte) || i_byte == CH_CR || i_byte == CH_LF) begin
                    if (r_code < STATUS_W'(CODE_MIN)) res = OUT_FAIL;
                    else if (i_byte == CH_LF) res = OUT_DONE;
                    else n_phase = (i_byte == CH_CR) ? PH_CR : PH_POST_CODE;
                end else begin
                    res = OUT_FAIL;
                end
            end
            PH_POST_CODE: begin
                if (i_byte > CH_SPACE) begin
                    n_rstart = r_pos;
                    n_phase  = PH_REASON;
                end else if (i_byte == CH_CR) begin
                    n_phase = PH_CR;
                end else if (i_byte == CH_LF) begin
                    res = OUT_DONE;
                end
            end
            PH_REASON: begin
                // Latch the length at the first blank of a run; a later word clears it.
                if (is_blank(i_byte) || i_byte == CH_CR || i_byte == CH_LF) begin
                    if (r_rlen == '0) n_rlen = r_pos - r_rstart;
                    if (i_byte == CH_CR) n_phase = PH_CR;
                    else if (i_byte == CH_LF) res = OUT_DONE;
                end else if (i_byte > CH_SPACE) begin
                    n_rlen = '0;
                end else begin
                    res = OUT_FAIL;
                end
            end
            PH_CR: begin
                if (i_byte == CH_LF) res = OUT_DONE;
                else res = OUT_FAIL;
            end
            default: begin
                res = OUT_FAIL;
            end
        endcase

        if (res == OUT_MORE) begin
            n_pos = pos_inc;
            if (pos_inc >= r_limit) res = OUT_FAIL;
        end

        // Hold the length of this byte for the result before the line state clears.
        rlen_done = n_rlen;

        // Return to the initial phase once the line ends either way.
        if (res != OUT_MORE) begin
            n_phase  = PH_SKIP;
            n_pos    = '0;
            n_major  = 1'b0;
            n_minor  = '0;
            n_code   = '0;
            n_rstart = '0;
            n_rlen   = '0;
        end
    end

    assign rstart_ext = (POS_W+REASON_W)'(r_rstart);
    assign rlen_ext   = (POS_W+REASON_W)'(rlen_done);
    assign len_ext    = (POS_W+LINE_LENGTH_W)'(pos_inc);

    always_comb begin
        o_res         = '0;
        o_res.outcome = res;
        if (res == OUT_DONE) begin
            o_res.version_major = r_major;
            o_res.version_minor = r_minor;
            o_res.status_value  = r_code;
            o_res.reason_offset = rstart_ext[REASON_W-1:0];
            o_res.reason_length = rlen_ext[REASON_W-1:0];
            o_res.line_length   = len_ext[LINE_LENGTH_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_SKIP;
            r_pos    <= '0;
            r_major  <= 1'b0;
            r_minor  <= '0;
            r_code   <= '0;
            r_rstart <= '0;
            r_rlen   <= '0;
            r_limit  <= POS_W'(LIMIT_RESET);
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                r_limit <= cfg_clamped[POS_W-1:0];
            end
            if (i_step) begin
                r_phase  <= n_phase;
                r_pos    <= n_pos;
                r_major  <= n_major;
                r_minor  <= n_minor;
                r_code   <= n_code;
                r_rstart <= n_rstart;
                r_rlen   <= n_rlen;
            end
        end
    end
endmodule

FILE: rtl/hsp_out_stage.sv
// ----------------------------------------------------------------------------
// hsp_out_stage
// Result register: holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module hsp_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  hsp_pkg::t_result i_res,
    output logic             o_free,
    hsp_result_if.source     o_result
);
    import hsp_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_free = !r_valid || o_result.ready;

    assign o_result.valid         = r_valid;
    assign o_result.outcome       = r_res.outcome;
    assign o_result.version_major = r_res.version_major;
    assign o_result.version_minor = r_res.version_minor;
    assign o_result.status_value  = r_res.status_value;
    assign o_result.reason_offset = r_res.reason_offset;
    assign o_result.reason_length = r_res.reason_length;
    assign o_result.line_length   = r_res.line_length;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end
endmodule

FILE: rtl/http_status_line_parser.sv
// ----------------------------------------------------------------------------
// http_status_line_parser
// Path: a byte held in the input register is decoded by the phase update in
// hsp_core and its result loaded into the result register. Throughput: one byte
// per cycle while the result register is free. Reset: synchronous active low;
// clears phase and counters, line_limit to the lesser of 1024 and MAX_LINE.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module http_status_line_parser #(
    parameter int MAX_LINE = hsp_pkg::MAX_LINE_DEFAULT
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    hsp_cfg_if.sink      i_cfg,
    hsp_byte_if.sink     i_line,
    hsp_result_if.source o_result
);
    import hsp_pkg::*;

    logic                   w_in_valid;
    logic [LINE_BYTE_W-1:0] w_in_byte;
    logic                   w_out_free;
    logic                   w_step;
    t_result                w_res;

    // Advance the core only when the result register can take the outcome.
    assign w_step = w_in_valid && w_out_free;

    hsp_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_line  (i_line),
        .i_step  (w_step),
        .o_valid (w_in_valid),
        .o_byte  (w_in_byte)
    );

    hsp_core #(
        .MAX_LINE (MAX_LINE)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .i_step  (w_step),
        .i_byte  (w_in_byte),
        .o_res   (w_res)
    );

    hsp_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_step),
        .i_res    (w_res),
        .o_free   (w_out_free),
        .o_result (o_result)
    );

    `HSP_ASSERT_IMP(a_fields_zero, i_clk, i_rst_n, o_result.valid && (o_result.outcome != OUT_DONE), (o_result.version_major == 1'b0) && (o_result.version_minor == '0) && (o_result.status_value == '0) && (o_result.reason_offset == '0) && (o_result.reason_length == '0) && (o_result.line_length == '0), "fields not zero on a result other than complete")
    `HSP_ASSERT_IMP(a_done_code, i_clk, i_rst_n, o_result.valid && (o_result.outcome == OUT_DONE), (o_result.status_value >= STATUS_W'(CODE_MIN)) && (o_result.status_value < STATUS_W'(CODE_LIMIT)) && (o_result.line_length != '0), "complete line with bad status code or length")
    `HSP_ASSERT_NXT(a_byte_held, i_clk, i_rst_n, w_in_valid && !w_step, w_in_valid && $stable(w_in_byte), "held byte lost while the result register is full")

endmodule

FILE: bench/http_status_line_parser_test.sv
// ----------------------------------------------------------------------------
// http_status_line_parser_test
// Self-checking bench for the HTTP status line parser. Bytes of mostly
// well-formed status lines go in under bursty flow; each result word is
// compared field by field with a byte-level model of the parser. The line
// limit is swept across its range between phases, out-of-range values too.
// ----------------------------------------------------------------------------
module http_status_line_parser_test;
    timeunit 1ns;
    timeprecision 1ps;
    import hsp_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int PHASE_ITEMS  = 115;
    localparam int N_LIMITS     = 7;

    typedef enum logic [3:0] {
        PH_IDLE, PH_GOT_H, PH_GOT_T, PH_GOT_TT, PH_GOT_P, PH_GOT_SLASH,
        PH_GOT_MAJOR, PH_GOT_DOT, PH_GOT_MINOR, PH_PRE_CODE, PH_CODE,
        PH_POST_CODE, PH_REASON, PH_GOT_CR
    } t_phase;

    class status_line_board;
        t_phase                   phase;
        logic [10:0]              pos;
        logic                     major;
        logic [3:0]               minor;
        logic [9:0]               code;
        logic [9:0]               r_start;
        logic [9:0]               r_len;
        logic [LINE_LIMIT_W-1:0]  limit;
        t_result                  expected_q[$];
        int                       fails;
        int                       results_seen;

        function new();
            limit        = LINE_LIMIT_RESET;
            fails        = 0;
            results_seen = 0;
            restart_line();
        endfunction

        function void restart_line();
            phase   = PH_IDLE;
            pos     = '0;
            major   = 1'b0;
            minor   = '0;
            code    = '0;
            r_start = '0;
            r_len   = '0;
        endfunction

        function void set_limit(input logic [LINE_LIMIT_W-1:0] value);
            limit = value;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function logic blank_char(input logic [7:0] c);
            return c == CH_SPACE || c == CH_TAB;
        endfunction

        function logic digit_char(input logic [7:0] c);
            return c >= CH_ZERO && c <= CH_NINE;
        endfunction

        // Fold case by clearing bit 5; only the letter pair can then match.
        function logic letter_is(input logic [7:0] c, input logic [7:0] upper_c);
            return (c & 8'hDF) == upper_c;
        endfunction

        function t_result parse_byte(input logic [7:0] c);
            t_result  r;
            t_outcome oc;
            int       v;
            int       lim;
            r  = '0;
            oc = OUT_MORE;
            case (phase)
                PH_IDLE: begin
                    if (letter_is(c, CH_H)) phase = PH_GOT_H;
                    else if (!blank_char(c)) oc = OUT_FAIL;
                end
                PH_GOT_H, PH_GOT_T: begin
                    if (letter_is(c, CH_T)) phase = t_phase'(phase + 4'd1);
                    else oc = OUT_FAIL;
                end
                PH_GOT_TT: begin
                    if (letter_is(c, CH_P)) phase = PH_GOT_P;
                    else oc = OUT_FAIL;
                end
                PH_GOT_P: begin
                    if (c == CH_SLASH) phase = PH_GOT_SLASH;
                    else oc = OUT_FAIL;
                end
                PH_GOT_SLASH: begin
                    if (c == CH_ZERO || c == CH_ONE) begin
                        major = c[0];
                        phase = PH_GOT_MAJOR;
                    end else oc = OUT_FAIL;
                end
                PH_GOT_MAJOR: begin
                    if (c == CH_DOT) phase = PH_GOT_DOT;
                    else oc = OUT_FAIL;
                end
                PH_GOT_DOT: begin
                    if (digit_char(c) && !(major && c > CH_ONE)) begin
                        minor = c[3:0];
                        phase = PH_GOT_MINOR;
                    end else oc = OUT_FAIL;
                end
                PH_GOT_MINOR: begin
                    if (blank_char(c)) phase = PH_PRE_CODE;
                    else oc = OUT_FAIL;
                end
                PH_PRE_CODE: begin
                    if (digit_char(c)) begin
                        code  = 10'(c[3:0]);
                        phase = PH_CODE;
                    end else if (!blank_char(c)) oc = OUT_FAIL;
                end
                PH_CODE: begin
                    if (digit_char(c)) begin
                        v = int'(code) * 10 + int'(c[3:0]);
                        if (v >= CODE_LIMIT) oc = OUT_FAIL;
                        else code = 10'(v);
                    end else if (blank_char(c) || c == CH_CR || c == CH_LF) begin
                        if (code < CODE_MIN) oc = OUT_FAIL;
                        else if (c == CH_LF) oc = OUT_DONE;
                        else phase = (c == CH_CR) ? PH_GOT_CR : PH_POST_CODE;
                    end else oc = OUT_FAIL;
                end
                PH_POST_CODE: begin
                    if (c > CH_SPACE) begin
                        r_start = pos[9:0];
                        phase   = PH_REASON;
                    end else if (c == CH_CR) phase = PH_GOT_CR;
                    else if (c == CH_LF) oc = OUT_DONE;
                end
                PH_REASON: begin
                    if (blank_char(c) || c == CH_CR || c == CH_LF) begin
                        // Length is fixed at the first blank after the last word.
                        if (r_len == 0) r_len = pos[9:0] - r_start;
                        if (c == CH_CR) phase = PH_GOT_CR;
                        else if (c == CH_LF) oc = OUT_DONE;
                    end else if (c > CH_SPACE) begin
                        r_len = '0;
                    end else oc = OUT_FAIL;
                end
                PH_GOT_CR: begin
                    if (c == CH_LF) oc = OUT_DONE;
                    else oc = OUT_FAIL;
                end
                default: oc = OUT_FAIL;
            endcase

            if (oc == OUT_DONE) begin
                r.version_major = major;
                r.version_minor = minor;
                r.status_value  = code;
                r.reason_offset = r_start;
                r.reason_length = r_len;
                r.line_length   = pos + 11'd1;
            end else if (oc == OUT_MORE) begin
                pos = pos + 11'd1;
                lim = int'(limit);
                if (lim < LINE_LIMIT_MIN) lim = LINE_LIMIT_MIN;
                if (lim > MAX_LINE_DEFAULT) lim = MAX_LINE_DEFAULT;
                if (int'(pos) >= lim) oc = OUT_FAIL;
            end
            r.outcome = oc;
            if (oc != OUT_MORE) restart_line();
            return r;
        endfunction

        function void note_byte(input logic [7:0] c);
            expected_q.push_back(parse_byte(c));
        endfunction

        task report(input string msg);
            $display("tb: result %0d: %s", results_seen, msg);
            fails++;
        endtask

        task compare_field(input string name, input logic [15:0] got,
                           input logic [15:0] want);
            if (got !== want)
                report($sformatf("%s got %0d expected %0d", name, got, want));
        endtask

        task check_result(input t_result got);
            t_result want;
            if (expected_q.size() == 0) begin
                report("result word with nothing expected");
            end else begin
                want = expected_q.pop_front();
                compare_field("outcome", 16'(got.outcome), 16'(want.outcome));
                compare_field("version_major", 16'(got.version_major),
                              16'(want.version_major));
                compare_field("version_minor", 16'(got.version_minor),
                              16'(want.version_minor));
                compare_field("status_value", 16'(got.status_value),
                              16'(want.status_value));
                compare_field("reason_offset", 16'(got.reason_offset),
                              16'(want.reason_offset));
                compare_field("reason_length", 16'(got.reason_length),
                              16'(want.reason_length));
                compare_field("line_length", 16'(got.line_length),
                              16'(want.line_length));
            end
            results_seen++;
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;

    hsp_cfg_if    cfg_ch();
    hsp_byte_if   line_ch();
    hsp_result_if result_ch();

    http_status_line_parser uut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_cfg    (cfg_ch),
        .i_line   (line_ch),
        .o_result (result_ch)
    );

    status_line_board board = new();

    logic [7:0]  line_bytes[$];
    int          bytes_sent  = 0;
    int          burst_left  = 0;
    int          idle_cycles = 0;
    logic [5:0]  stall_step  = '0;
    logic [15:0] stall_mask  = 16'hFFFF;

    always #4 clk = ~clk;

    // Receiver stall pattern, redrawn whenever the step counter wraps; never all-stall.
    always @(negedge clk) begin
        if (stall_step == 0)
            stall_mask <= ($urandom_range(0, 2) == 0) ? 16'hFFFF
                                                      : (16'($urandom) | 16'h0001);
        result_ch.ready <= stall_mask[stall_step[3:0]];
        stall_step      <= stall_step + 6'd1;
    end

    always @(posedge clk) begin
        t_result got;
        if (rst_n) begin
            if (result_ch.valid && result_ch.ready) begin
                got.outcome       = t_outcome'(result_ch.outcome);
                got.version_major = result_ch.version_major;
                got.version_minor = result_ch.version_minor;
                got.status_value  = result_ch.status_value;
                got.reason_offset = result_ch.reason_offset;
                got.reason_length = result_ch.reason_length;
                got.line_length   = result_ch.line_length;
                board.check_result(got);
            end
            if ((result_ch.valid && result_ch.ready) || (line_ch.valid && line_ch.ready)
                    || (cfg_ch.valid && cfg_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        wait (idle_cycles >= STALL_LIMIT);
        $display("tb: failure");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 40);
            if (gap > 0) begin
                @(negedge clk);
                line_ch.valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        @(negedge clk);
        line_ch.valid     <= 1'b1;
        line_ch.line_byte <= b;
        do @(posedge clk); while (!line_ch.ready);
        board.note_byte(b);
        burst_left--;
        bytes_sent++;
    endtask

    task automatic send_line();
        foreach (line_bytes[i]) send_byte(line_bytes[i]);
    endtask

    task automatic write_limit(input logic [LINE_LIMIT_W-1:0] value);
        @(negedge clk);
        line_ch.valid <= 1'b0;
        // Drain every outstanding result before touching the register.
        while (board.pending() != 0) @(posedge clk);
        @(negedge clk);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.line_limit <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        board.set_limit(value);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic void push_blank();
        line_bytes.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
    endfunction

    function automatic void push_number(input int n);
        string s;
        s = $sformatf("%0d", n);
        for (int i = 0; i < s.len(); i++) line_bytes.push_back(s[i]);
    endfunction

    // Fill line_bytes with one status line; long_len > 0 gives one long reason word.
    function automatic void build_line(input int word_max, input int long_len);
        string       hdr;
        logic [7:0]  b;
        int          major;
        int          minor;
        int          code;
        int          tail;
        int          cut;
        hdr = "HTTP";
        line_bytes.delete();
        repeat ($urandom_range(0, 2)) push_blank();
        for (int i = 0; i < 4; i++) begin
            b = hdr[i];
            if ($urandom_range(0, 1)) b = b | CASE_GAP;
            line_bytes.push_back(b);
        end
        line_bytes.push_back(CH_SLASH);
        major = ($urandom_range(0, 9) == 0) ? $urandom_range(2, 9) : $urandom_range(0, 1);
        line_bytes.push_back(8'(int'(CH_ZERO) + major));
        line_bytes.push_back(CH_DOT);
        if (major == 1)
            minor = ($urandom_range(0, 7) == 0) ? $urandom_range(2, 9) : $urandom_range(0, 1);
        else
            minor = $urandom_range(0, 9);
        line_bytes.push_back(8'(int'(CH_ZERO) + minor));
        repeat ($urandom_range(1, 2)) push_blank();
        case ($urandom_range(0, 15))
            0:       code = $urandom_range(0, 99);
            1:       code = $urandom_range(600, 999);
            default: code = $urandom_range(100, 599);
        endcase
        if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 2)) line_bytes.push_back(CH_ZERO);
        push_number(code);

        if (long_len > 0) begin
            line_bytes.push_back(CH_SPACE);
            repeat (long_len) line_bytes.push_back(8'($urandom_range(8'h21, 8'h7E)));
            line_bytes.push_back(CH_CR);
            line_bytes.push_back(CH_LF);
            return;
        end

        tail = $urandom_range(0, 9);
        if (tail == 0) begin
            line_bytes.push_back(CH_LF);
        end else if (tail == 1) begin
            line_bytes.push_back(CH_CR);
            line_bytes.push_back(CH_LF);
        end else begin
            // Blanks and low control bytes between code and reason
            repeat ($urandom_range(1, 3)) begin
                b = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 32)) : CH_SPACE;
                if (b == CH_CR || b == CH_LF) b = CH_TAB;
                line_bytes.push_back(b);
            end
            if (tail != 2) begin
                for (int w = $urandom_range(1, 3); w > 0; w--) begin
                    repeat ($urandom_range(1, word_max))
                        line_bytes.push_back(8'($urandom_range(8'h21, 8'hFF)));
                    if (w > 1) repeat ($urandom_range(1, 2)) push_blank();
                end
                repeat ($urandom_range(0, 2)) push_blank();
                if ($urandom_range(0, 11) == 0) line_bytes.push_back(8'($urandom_range(0, 31)));
            end
            case ($urandom_range(0, 11))
                0: line_bytes.push_back(CH_LF);
                1: begin
                    line_bytes.push_back(CH_CR);
                    line_bytes.push_back(8'($urandom));
                    line_bytes.push_back(CH_LF);
                end
                default: begin
                    line_bytes.push_back(CH_CR);
                    line_bytes.push_back(CH_LF);
                end
            endcase
        end

        // Break some lines: overwrite or truncate, then close with LF.
        if ($urandom_range(0, 7) == 0) begin
            cut = $urandom_range(0, line_bytes.size() - 1);
            if ($urandom_range(0, 1)) line_bytes[cut] = 8'($urandom);
            else while (line_bytes.size() > cut) void'(line_bytes.pop_back());
            line_bytes.push_back(CH_LF);
        end
    endfunction

    function automatic void build_noise();
        line_bytes.delete();
        repeat ($urandom_range(1, 6)) line_bytes.push_back(8'($urandom));
        line_bytes.push_back(CH_LF);
    endfunction

    initial begin
        logic [7:0] opening[] = '{
            CH_TAB, "h", "T", "t", "P", CH_SLASH, "0", CH_DOT, "9", CH_SPACE,
            "0", "2", "0", "0", CH_SPACE, 8'h01, "A", 8'hFF, CH_SPACE, CH_CR, CH_LF,
            8'hFF, 8'h00
        };
        logic [LINE_LIMIT_W-1:0] limits[N_LIMITS] = '{
            11'd16, 11'd0, 11'd2047, 11'd37, 11'd1024, 11'd1500, 11'd300
        };
        int stop_at;

        rst_n             = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.line_limit = '0;
        line_ch.valid     = 1'b0;
        line_ch.line_byte = '0;
        result_ch.ready   = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (opening[i]) send_byte(opening[i]);

        for (int p = 0; p < N_LIMITS; p++) begin
            write_limit(limits[p]);
            stop_at = bytes_sent + PHASE_ITEMS;
            // One line around the maximum length, where the limit clamps to MAX_LINE.
            if (limits[p] == 11'd2047) begin
                build_line(4, $urandom_range(990, 1015));
                send_line();
            end
            while (bytes_sent < stop_at) begin
                if ($urandom_range(0, 9) == 0) build_noise();
                else build_line(6, 0);
                send_line();
            end
        end

        @(negedge clk);
        line_ch.valid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        if (board.fails == 0 && board.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/hsp_pkg.sv
rtl/hsp_byte_if.sv
rtl/hsp_result_if.sv
rtl/hsp_cfg_if.sv
rtl/hsp_in_stage.sv
rtl/hsp_core.sv
rtl/hsp_out_stage.sv
rtl/http_status_line_parser.sv
bench/http_status_line_parser_test.sv
